// File: rtl/core/rrtt_pkg.sv
// Shared types and constants for the round-robin thread table.
package rrtt_pkg;

  // Fixed field widths of the stream words
  localparam int CMD_W      = 2;
  localparam int TID_W      = 16;
  localparam int STS_W      = 3;
  localparam int OID_W      = 16;
  localparam int OSLOT_W    = 4;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE = 2'd0,
    CMD_YIELD  = 2'd1,
    CMD_EXIT   = 2'd2,
    CMD_JOIN   = 2'd3
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK        = 3'd0,
    STS_NO_FREE   = 3'd1,
    STS_NOT_FOUND = 3'd2,
    STS_SELF      = 3'd3,
    STS_PENDING   = 3'd4
  } sts_t;

  typedef enum logic [1:0] {
    SL_FREE     = 2'd0,
    SL_RUNNABLE = 2'd1,
    SL_RUNNING  = 2'd2,
    SL_ZOMBIE   = 2'd3
  } slot_st_t;

  typedef enum logic [1:0] {
    SCAN_CREATE = 2'd0,
    SCAN_YIELD  = 2'd1,
    SCAN_JOIN   = 2'd2
  } scan_mode_t;

  typedef enum logic [2:0] {
    WR_NONE   = 3'd0,
    WR_CREATE = 3'd1,
    WR_EXIT   = 3'd2,
    WR_OLD    = 3'd3,
    WR_NEW    = 3'd4,
    WR_FREE   = 3'd5
  } wr_op_t;

  // Controller -> datapath
  typedef struct packed {
    logic       load_in;
    logic       scan_start;
    scan_mode_t scan_mode;
    logic       scan_run;
    wr_op_t     wr_op;
    logic       set_sts;
    sts_t       sts;
    logic       out_load;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic       hit;
    logic       scan_end;
    logic       hit_cur;
    logic       hit_zombie;
    logic       out_free;
    scan_mode_t mode;
  } dp_sts_t;

endpackage

// File: rtl/core/rrtt_dp.sv
// Datapath: slot memory, scan pointer, running-slot state, id counter, result register.
module rrtt_dp #(
  parameter int SLOTS    = 16,
  parameter int ID_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [rrtt_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  rrtt_pkg::dp_cmd_t                   cmd,
  output rrtt_pkg::dp_sts_t                   sts,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rrtt_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNTW = $clog2(SLOTS + 1);
  localparam int CW   = (ID_WIDTH > rrtt_pkg::TID_W) ? ID_WIDTH : rrtt_pkg::TID_W;
  localparam int XW   = (IW > rrtt_pkg::OSLOT_W) ? IW : rrtt_pkg::OSLOT_W;

  typedef struct packed {
    rrtt_pkg::slot_st_t  st;
    logic [ID_WIDTH-1:0] id;
  } entry_t;

  entry_t mem [SLOTS];
  logic [SLOTS-1:0] vld_r;

  // item registers
  logic [rrtt_pkg::TID_W-1:0] target_r;
  logic [IW-1:0]              prev_r;
  rrtt_pkg::sts_t             sts_r;
  logic [ID_WIDTH-1:0]        new_id_r;

  // scheduler state
  logic [IW-1:0]       cur_r;
  logic [ID_WIDTH-1:0] cur_id_r;
  logic                cur_zmb_r;
  logic [ID_WIDTH-1:0] ctr_r;

  // scan
  rrtt_pkg::scan_mode_t mode_r;
  logic [IW-1:0]        ptr_r;
  logic [CNTW-1:0]      cnt_r;
  logic                 chk_v_r;
  logic                 chk_last_r;
  entry_t               rd_q_r;
  logic                 rd_v_r;
  logic [IW-1:0]        rd_slot_r;
  logic [IW-1:0]        hit_slot_r;
  logic [ID_WIDTH-1:0]  hit_id_r;

  // result register
  logic                                out_valid_r;
  logic [rrtt_pkg::OUT_TDATA_W-1:0]    out_data_r;

  entry_t              eff;
  logic                match;
  logic                issue;
  logic [IW-1:0]       ptr_inc;
  logic [IW-1:0]       cur_inc;
  logic [ID_WIDTH-1:0] ctr_inc;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  entry_t              wr_data;
  logic [CW-1:0]       eff_id_x;
  logic [CW-1:0]       tgt_x;
  logic [XW-1:0]       prev_x;
  logic [XW-1:0]       cur_x;
  logic [CW-1:0]       new_id_x;
  logic [CW-1:0]       cur_id_x;

  // Entry seen by the check stage; never-written entries read as after reset
  always_comb begin
    if (rd_v_r) begin
      eff = rd_q_r;
    end else if (rd_slot_r == '0) begin
      eff = '{st: rrtt_pkg::SL_RUNNING, id: '0};
    end else begin
      eff = '{st: rrtt_pkg::SL_FREE, id: '1};
    end
  end

  assign eff_id_x = CW'(eff.id);
  assign tgt_x    = CW'(target_r);

  always_comb begin
    case (mode_r)
      rrtt_pkg::SCAN_CREATE: match = chk_v_r && (eff.st == rrtt_pkg::SL_FREE);
      rrtt_pkg::SCAN_YIELD:  match = chk_v_r && (eff.st == rrtt_pkg::SL_RUNNABLE);
      rrtt_pkg::SCAN_JOIN:   match = chk_v_r && (eff.st != rrtt_pkg::SL_FREE) &&
                                     (eff_id_x == tgt_x);
      default:               match = 1'b0;
    endcase
  end

  assign sts.hit        = match;
  assign sts.scan_end   = chk_v_r && chk_last_r;
  assign sts.hit_cur    = (rd_slot_r == cur_r);
  assign sts.hit_zombie = (eff.st == rrtt_pkg::SL_ZOMBIE);
  assign sts.out_free   = !out_valid_r || out_tready;
  assign sts.mode       = mode_r;

  assign issue   = cmd.scan_run && (cnt_r != CNTW'(SLOTS));
  assign ptr_inc = (ptr_r == IW'(SLOTS - 1)) ? '0 : ptr_r + 1'b1;
  assign cur_inc = (cur_r == IW'(SLOTS - 1)) ? '0 : cur_r + 1'b1;
  assign ctr_inc = (ctr_r == '1) ? ID_WIDTH'(1) : ctr_r + 1'b1;

  // write port
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = hit_slot_r;
    wr_data = '{st: rrtt_pkg::SL_FREE, id: '1};
    unique case (cmd.wr_op)
      rrtt_pkg::WR_CREATE: wr_data = '{st: rrtt_pkg::SL_RUNNABLE, id: ctr_r};
      rrtt_pkg::WR_EXIT: begin
        wr_addr = cur_r;
        wr_data = '{st: rrtt_pkg::SL_ZOMBIE, id: cur_id_r};
      end
      rrtt_pkg::WR_OLD: begin
        wr_addr = cur_r;
        wr_data = '{st: cur_zmb_r ? rrtt_pkg::SL_ZOMBIE : rrtt_pkg::SL_RUNNABLE,
                    id: cur_id_r};
      end
      rrtt_pkg::WR_NEW:  wr_data = '{st: rrtt_pkg::SL_RUNNING, id: hit_id_r};
      rrtt_pkg::WR_FREE: wr_data = '{st: rrtt_pkg::SL_FREE, id: '1};
      default:           wr_en = 1'b0;
    endcase
  end

  // slot memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r    <= mem[ptr_r];
    rd_v_r    <= vld_r[ptr_r];
    rd_slot_r <= ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= rrtt_pkg::SCAN_CREATE;
      ptr_r      <= '0;
      cnt_r      <= '0;
      chk_v_r    <= 1'b0;
      chk_last_r <= 1'b0;
    end else if (cmd.scan_start) begin
      mode_r     <= cmd.scan_mode;
      ptr_r      <= (cmd.scan_mode == rrtt_pkg::SCAN_YIELD) ? cur_inc : '0;
      cnt_r      <= '0;
      chk_v_r    <= 1'b0;
      chk_last_r <= 1'b0;
    end else if (issue) begin
      ptr_r      <= ptr_inc;
      cnt_r      <= cnt_r + 1'b1;
      chk_v_r    <= 1'b1;
      chk_last_r <= (cnt_r == CNTW'(SLOTS - 1));
    end else begin
      chk_v_r    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_run && match) begin
      hit_slot_r <= rd_slot_r;
      hit_id_r   <= eff.id;
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      target_r <= in_tdata[rrtt_pkg::CMD_W +: rrtt_pkg::TID_W];
      prev_r   <= cur_r;
    end
    if (cmd.load_in) begin
      sts_r <= rrtt_pkg::STS_OK;
    end else if (cmd.set_sts) begin
      sts_r <= cmd.sts;
    end
    if (cmd.load_in) begin
      new_id_r <= '0;
    end else if (cmd.wr_op == rrtt_pkg::WR_CREATE) begin
      new_id_r <= ctr_r;
    end
  end

  // running slot and id counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r     <= '0;
      cur_id_r  <= '0;
      cur_zmb_r <= 1'b0;
      ctr_r     <= ID_WIDTH'(1);
    end else begin
      if (cmd.wr_op == rrtt_pkg::WR_CREATE) begin
        ctr_r <= ctr_inc;
      end
      if (cmd.wr_op == rrtt_pkg::WR_EXIT) begin
        cur_zmb_r <= 1'b1;
      end else if (cmd.wr_op == rrtt_pkg::WR_NEW) begin
        cur_r     <= hit_slot_r;
        cur_id_r  <= hit_id_r;
        cur_zmb_r <= 1'b0;
      end
    end
  end

  // result word
  assign prev_x   = XW'(prev_r);
  assign cur_x    = XW'(cur_r);
  assign new_id_x = CW'(new_id_r);
  assign cur_id_x = CW'(cur_id_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {4'd0,
                     cur_id_x[rrtt_pkg::OID_W-1:0],
                     cur_x[rrtt_pkg::OSLOT_W-1:0],
                     prev_x[rrtt_pkg::OSLOT_W-1:0],
                     (cur_r != prev_r),
                     new_id_x[rrtt_pkg::OID_W-1:0],
                     sts_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: rtl/core/rrtt_ctrl.sv
// Controller: sequences scans and table writes for each command word.
module rrtt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  rrtt_pkg::cmd_t      in_cmd,
  input  rrtt_pkg::dp_sts_t   sts,
  output rrtt_pkg::dp_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXIT, S_SCAN, S_CREATE, S_OLD, S_NEW, S_FREE, S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.scan_mode  = rrtt_pkg::SCAN_YIELD;
    cmd.wr_op      = rrtt_pkg::WR_NONE;
    cmd.sts        = rrtt_pkg::STS_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          unique case (in_cmd)
            rrtt_pkg::CMD_CREATE: begin
              cmd.scan_start = 1'b1;
              cmd.scan_mode  = rrtt_pkg::SCAN_CREATE;
              state_nxt      = S_SCAN;
            end
            rrtt_pkg::CMD_YIELD: begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
            rrtt_pkg::CMD_EXIT: state_nxt = S_EXIT;
            rrtt_pkg::CMD_JOIN: begin
              cmd.scan_start = 1'b1;
              cmd.scan_mode  = rrtt_pkg::SCAN_JOIN;
              state_nxt      = S_SCAN;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_EXIT: begin
        cmd.wr_op      = rrtt_pkg::WR_EXIT;
        cmd.scan_start = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.hit) begin
          case (sts.mode)
            rrtt_pkg::SCAN_CREATE: state_nxt = S_CREATE;
            rrtt_pkg::SCAN_YIELD:  state_nxt = sts.hit_cur ? S_DONE : S_OLD;
            rrtt_pkg::SCAN_JOIN: begin
              priority if (sts.hit_cur) begin
                cmd.set_sts = 1'b1;
                cmd.sts     = rrtt_pkg::STS_SELF;
                state_nxt   = S_DONE;
              end else if (sts.hit_zombie) begin
                state_nxt = S_FREE;
              end else begin
                // target still alive: one yield, then report pending
                cmd.set_sts    = 1'b1;
                cmd.sts        = rrtt_pkg::STS_PENDING;
                cmd.scan_start = 1'b1;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end else if (sts.scan_end) begin
          case (sts.mode)
            rrtt_pkg::SCAN_CREATE: begin
              cmd.set_sts = 1'b1;
              cmd.sts     = rrtt_pkg::STS_NO_FREE;
            end
            rrtt_pkg::SCAN_JOIN: begin
              cmd.set_sts = 1'b1;
              cmd.sts     = rrtt_pkg::STS_NOT_FOUND;
            end
            default: cmd.set_sts = 1'b0;
          endcase
          state_nxt = S_DONE;
        end
      end
      S_CREATE: begin
        cmd.wr_op = rrtt_pkg::WR_CREATE;
        state_nxt = S_DONE;
      end
      S_OLD: begin
        cmd.wr_op = rrtt_pkg::WR_OLD;
        state_nxt = S_NEW;
      end
      S_NEW: begin
        cmd.wr_op = rrtt_pkg::WR_NEW;
        state_nxt = S_DONE;
      end
      S_FREE: begin
        cmd.wr_op = rrtt_pkg::WR_FREE;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: rtl/core/round_robin_thread_table.sv
// Top level of the round-robin thread table: controller, datapath and checks.
//
// Cooperative thread scheduler. Each input word is one command (create, yield,
// exit, join) and yields exactly one result word: status, id of a created
// thread, whether the running slot changed, the slot running before and after,
// and the id now running. After reset slot 0 runs with id 0, every other slot
// is free and the next id is 1; ids wrap from all ones back to 1. Join never
// blocks: if the target is still alive it yields once and reports pending, and
// software retries. One command is processed at a time. Slot state lives in a
// memory with one read and one write port that is scanned one slot per clock;
// a create, yield or join scan stops early when the wanted slot is found. Exit
// writes its slot as a zombie before its yield scan, and a pending join runs a
// second, yield scan after the join scan. A finished result sits in an output
// register, so the next command word is taken while it waits for the consumer;
// a command that finishes while that register still holds an untaken word
// waits until it is taken.
module round_robin_thread_table #(
  parameter int SLOTS    = 16,
  parameter int ID_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // command word in
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rrtt_pkg::IN_TDATA_W-1:0]   in_tdata,   // cmd[1:0], target_id[17:2]
  // result word out
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rrtt_pkg::OUT_TDATA_W-1:0]  out_tdata   // status[2:0], new_id[18:3],
                                                        // switched[19], prev_slot[23:20],
                                                        // run_slot[27:24], run_id[43:28]
);

  rrtt_pkg::dp_cmd_t dp_cmd;
  rrtt_pkg::dp_sts_t dp_sts;
  rrtt_pkg::cmd_t    in_cmd;

  assign in_cmd = rrtt_pkg::cmd_t'(in_tdata[rrtt_pkg::CMD_W-1:0]);

  // Sequencer: decides scan kind, which table writes follow and the status code
  rrtt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_cmd),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  // Slot table, running-slot registers, id counter and the result register
  rrtt_dp #(
    .SLOTS    (SLOTS),
    .ID_WIDTH (ID_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (dp_cmd),
    .sts        (dp_sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Result word fields for the checks
  logic [rrtt_pkg::STS_W-1:0] chk_status;
  logic [rrtt_pkg::OID_W-1:0] chk_new_id;
  logic                       chk_switched;

  assign chk_status   = out_tdata[2:0];
  assign chk_new_id   = out_tdata[18:3];
  assign chk_switched = out_tdata[19];

  // A command never finishes in the cycle it is taken, so input stalls right after a take
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again the cycle after a command word");

  // A new id is only handed out by a successful create
  a_new_id_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (chk_new_id != '0) |-> chk_status == rrtt_pkg::STS_OK)
    else $error("new id reported with a failing status");

  // Failed create and join on self or missing target never switch threads
  a_no_switch_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (chk_status == rrtt_pkg::STS_NO_FREE ||
                   chk_status == rrtt_pkg::STS_NOT_FOUND ||
                   chk_status == rrtt_pkg::STS_SELF) |-> !chk_switched)
    else $error("running slot changed on a failed command");

endmodule

// File: dv/rrtt_sched_checker.sv
`timescale 1ns / 100ps
// Scheduler checker: predicts each result word and compares it with the DUT output.
module rrtt_sched_checker
  import rrtt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // cmd[1:0], target_id[17:2]
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,   // status, new_id, switched, prev, run, run_id
  output int                     fail_count,
  output int                     outstanding,
  output logic [TID_W-1:0]       pred_next_id
);

  localparam int NSLOT = 16;

  // Packed from the top down so that status lands in the low bits.
  typedef struct packed {
    logic [OID_W-1:0]   run_id;
    logic [OSLOT_W-1:0] run_slot;
    logic [OSLOT_W-1:0] prev_slot;
    logic               switched;
    logic [OID_W-1:0]   new_id;
    sts_t               status;
  } sched_res_t;

  slot_st_t           slot_st  [NSLOT];
  logic [TID_W-1:0]   slot_tid [NSLOT];
  logic [OSLOT_W-1:0] cur_slot;
  logic [TID_W-1:0]   tid_ctr;
  sched_res_t         result_q [$];

  // Round-robin search for a runnable slot, starting after the current one.
  function automatic void switch_to_next();
    logic [OSLOT_W-1:0] s;
    for (int i = 1; i < NSLOT; i++) begin
      s = cur_slot + OSLOT_W'(i);
      if (slot_st[s] == SL_RUNNABLE) begin
        if (slot_st[cur_slot] == SL_RUNNING) slot_st[cur_slot] = SL_RUNNABLE;
        slot_st[s] = SL_RUNNING;
        cur_slot = s;
        return;
      end
    end
  endfunction

  function automatic sched_res_t apply_command(cmd_t cmd, logic [TID_W-1:0] target);
    sched_res_t r;
    int         hit;
    r = '0;
    r.status = STS_OK;
    r.prev_slot = cur_slot;
    case (cmd)
      CMD_CREATE: begin
        r.status = STS_NO_FREE;
        for (int i = 0; i < NSLOT; i++) begin
          if (slot_st[i] == SL_FREE) begin
            slot_st[i] = SL_RUNNABLE;
            slot_tid[i] = tid_ctr;
            r.new_id = tid_ctr;
            r.status = STS_OK;
            tid_ctr = (tid_ctr == '1) ? TID_W'(1) : tid_ctr + 1'b1;
            break;
          end
        end
      end
      CMD_YIELD: switch_to_next();
      CMD_EXIT: begin
        slot_st[cur_slot] = SL_ZOMBIE;
        switch_to_next();
      end
      default: begin
        hit = -1;
        for (int i = 0; i < NSLOT; i++) begin
          if (slot_st[i] != SL_FREE && slot_tid[i] == target) begin
            hit = i;
            break;
          end
        end
        if (hit < 0) begin
          r.status = STS_NOT_FOUND;
        end else if (hit == int'(cur_slot)) begin
          r.status = STS_SELF;
        end else if (slot_st[hit] == SL_ZOMBIE) begin
          slot_st[hit] = SL_FREE;
          slot_tid[hit] = '1;
        end else begin
          switch_to_next();
          r.status = STS_PENDING;
        end
      end
    endcase
    r.run_slot = cur_slot;
    r.switched = (cur_slot != r.prev_slot);
    r.run_id = slot_tid[cur_slot];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
    if (exp_val !== got_val) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, got_val);
    end
  endtask

  always @(posedge clk) begin
    sched_res_t want;
    sched_res_t got;
    if (!rst_n) begin
      for (int i = 0; i < NSLOT; i++) begin
        slot_st[i] = SL_FREE;
        slot_tid[i] = '1;
      end
      slot_st[0] = SL_RUNNING;
      slot_tid[0] = '0;
      cur_slot = '0;
      tid_ctr = TID_W'(1);
      result_q.delete();
      fail_count = 0;
    end else begin
      // Compare before pushing: a word leaving now never belongs to one entering now.
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(sched_res_t)-1:0];
        if (result_q.size() == 0) begin
          fail_count++;
          $display("%0t: result word %0h with nothing expected", $time, out_tdata);
        end else begin
          want = result_q.pop_front();
          check_field("status", want.status, got.status);
          check_field("new_id", want.new_id, got.new_id);
          check_field("switched", want.switched, got.switched);
          check_field("prev_slot", want.prev_slot, got.prev_slot);
          check_field("run_slot", want.run_slot, got.run_slot);
          check_field("run_id", want.run_id, got.run_id);
        end
      end
      if (in_tvalid && in_tready)
        result_q.push_back(apply_command(cmd_t'(in_tdata[CMD_W-1:0]),
                                         in_tdata[CMD_W +: TID_W]));
    end
    outstanding = result_q.size();
    pred_next_id = tid_ctr;
  end

endmodule

// File: dv/round_robin_thread_table_tb.sv
`timescale 1ns / 100ps
// Testbench top for the round-robin thread table: stimulus, flow control and verdict.
module round_robin_thread_table_tb;
  import rrtt_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_WORDS = 1050;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // cmd[1:0], target_id[17:2], zero pad
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;   // status[2:0], new_id[18:3], switched[19],
                                       // prev_slot[23:20], run_slot[27:24], run_id[43:28]
  int                     fail_count;
  int                     outstanding;
  logic [TID_W-1:0]       pred_next_id;  // id the next create will hand out

  int                     src_idle_pct   = 0;
  int                     sink_stall_pct = 0;
  int unsigned            cycle_cnt      = 0;

  round_robin_thread_table #(
    .SLOTS    (16),
    .ID_WIDTH (16)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  rrtt_sched_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .pred_next_id (pred_next_id)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a word never comes back.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sink side: random back-pressure, rate set by the current phase.
  always @(negedge clk)
    out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

  // One command word. Called at a falling edge, returns at a falling edge.
  // in_tvalid is only dropped inside the idle loop, so back-to-back words
  // keep it high without a low/high pair in the same step.
  task automatic send_word(input cmd_t cmd, input logic [TID_W-1:0] tgt);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_TDATA_W'($urandom);   // junk while idle
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-CMD_W-TID_W){1'b0}}, tgt, cmd};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  initial begin
    cmd_t             cmd;
    logic [TID_W-1:0] tgt;
    int               pick;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed part ----
    // Thread 0 exits with nobody runnable: its zombie slot stays current.
    send_word(CMD_EXIT, '0);
    send_word(CMD_YIELD, '0);          // nothing runnable, no switch
    send_word(CMD_JOIN, '0);           // joining the zombie that is still current -> self
    send_word(CMD_CREATE, 16'hA5A5);   // id 1 in slot 1
    send_word(CMD_YIELD, '0);          // switch to slot 1, slot 0 stays zombie
    send_word(CMD_JOIN, '0);           // reap slot 0
    // Fill every slot, then one create too many.
    repeat (15) send_word(CMD_CREATE, '1);
    send_word(CMD_CREATE, '0);         // table full
    send_word(CMD_JOIN, 16'd5);        // target alive -> yield + pending
    send_word(CMD_EXIT, 16'h5A5A);     // current becomes zombie, next one runs
    send_word(CMD_JOIN, 16'd4);        // id 4 is the thread now running -> self
    send_word(CMD_JOIN, 16'hFFFF);     // all-ones id only sits in free slots

    // ---- random part, four flow-control phases ----
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 80; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 80; end
        default: begin src_idle_pct = 38; sink_stall_pct = 38; end
      endcase
      for (int n = 0; n < RANDOM_WORDS / 4; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 30)      cmd = CMD_CREATE;
        else if (pick < 55) cmd = CMD_YIELD;
        else if (pick < 70) cmd = CMD_EXIT;
        else                cmd = CMD_JOIN;
        // Most joins aim at recently issued ids so they hit live or zombie
        // threads; the rest are thread 0 or pure noise.
        pick = $urandom_range(0, 99);
        if (pick < 70)      tgt = pred_next_id - TID_W'($urandom_range(1, 20));
        else if (pick < 80) tgt = '0;
        else                tgt = TID_W'($urandom);
        send_word(cmd, tgt);
      end
    end

    // ---- drain ----
    in_tvalid      <= 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: round_robin_thread_table.f
rtl/core/rrtt_pkg.sv
rtl/core/rrtt_dp.sv
rtl/core/rrtt_ctrl.sv
rtl/core/round_robin_thread_table.sv
dv/rrtt_sched_checker.sv
dv/round_robin_thread_table_tb.sv
